FILE: src/sref_pkg.sv
// ----------------------------------------------------------------------------
// Sequence range error filter package
// Shared sizes, operation and status codes, and the control and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package sref_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    FUNC_OPEN   = 2'd0,
    FUNC_CLOSE  = 2'd1,
    FUNC_RETIRE = 2'd2,
    FUNC_CHECK  = 2'd3
  } func_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_OPEN = 2'd2;

  typedef struct packed {
    logic load_in;
    logic scan_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

FILE: src/sref_datapath.sv
// ----------------------------------------------------------------------------
// Sequence range error filter datapath
// Holds the range table, the captured request and the result registers, and
// evaluates one table entry per scan cycle.
// ----------------------------------------------------------------------------
module sref_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sref_pkg::cmd_t           cmd,
  output sref_pkg::sts_t           sts,
  input  logic [1:0]               in_func,
  input  logic [7:0]               in_error_code,
  input  logic [31:0]              in_first_sequence,
  input  logic [31:0]              in_sequence_req,
  output logic                     out_ignored,
  output logic [1:0]               out_status
);

  localparam logic [sref_pkg::IDX_W-1:0] LAST_IDX = sref_pkg::IDX_W'(sref_pkg::ENTRIES - 1);

  logic                        valid_r [sref_pkg::ENTRIES];
  logic [7:0]                  code_r  [sref_pkg::ENTRIES];
  logic [31:0]                 start_r [sref_pkg::ENTRIES];
  logic [31:0]                 end_r   [sref_pkg::ENTRIES];

  sref_pkg::func_t             func_r;
  logic [7:0]                  req_code_r;
  logic [31:0]                 req_first_r;
  logic [31:0]                 req_seq_r;
  logic [sref_pkg::IDX_W-1:0]  idx_r;
  logic                        res_ignored_r;
  logic [1:0]                  res_status_r;
  logic                        out_ignored_r;
  logic [1:0]                  out_status_r;

  logic                        ent_valid;
  logic [7:0]                  ent_code;
  logic [31:0]                 ent_start;
  logic [31:0]                 ent_end;
  logic                        code_eq;
  logic                        end_zero;
  logic                        open_hit;
  logic                        close_hit;
  logic                        retire_hit;
  logic                        check_hit;
  logic                        stop_hit;
  logic                        last;
  logic                        ignored_nxt;
  logic [1:0]                  status_nxt;

  always_comb begin
    ent_valid  = valid_r[idx_r];
    ent_code   = code_r[idx_r];
    ent_start  = start_r[idx_r];
    ent_end    = end_r[idx_r];
    code_eq    = (ent_code == req_code_r);
    end_zero   = (ent_end == 32'd0);
    open_hit   = !ent_valid;
    close_hit  = ent_valid && code_eq && (ent_start == req_first_r) && end_zero;
    retire_hit = ent_valid && !end_zero && (req_seq_r >= ent_end);
    check_hit  = ent_valid && code_eq && (req_seq_r > ent_start) &&
                 (end_zero || (req_seq_r < ent_end));
    last       = (idx_r == LAST_IDX);
    case (func_r)
      sref_pkg::FUNC_OPEN:   stop_hit = open_hit;
      sref_pkg::FUNC_CLOSE:  stop_hit = close_hit;
      sref_pkg::FUNC_CHECK:  stop_hit = check_hit;
      default:               stop_hit = 1'b0;
    endcase
    ignored_nxt = (func_r == sref_pkg::FUNC_CHECK) && check_hit;
    case (func_r)
      sref_pkg::FUNC_OPEN:   status_nxt = open_hit  ? sref_pkg::ST_OK : sref_pkg::ST_FULL;
      sref_pkg::FUNC_CLOSE:  status_nxt = close_hit ? sref_pkg::ST_OK : sref_pkg::ST_NO_OPEN;
      default:               status_nxt = sref_pkg::ST_OK;
    endcase
    sts.done = stop_hit || last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sref_pkg::ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.scan_en) begin
      if ((func_r == sref_pkg::FUNC_OPEN) && open_hit) begin
        valid_r[idx_r] <= 1'b1;
      end else if ((func_r == sref_pkg::FUNC_RETIRE) && retire_hit) begin
        valid_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      if ((func_r == sref_pkg::FUNC_OPEN) && open_hit) begin
        code_r[idx_r]  <= req_code_r;
        start_r[idx_r] <= req_seq_r;
        end_r[idx_r]   <= 32'd0;
      end else if ((func_r == sref_pkg::FUNC_CLOSE) && close_hit) begin
        end_r[idx_r]   <= req_seq_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r      <= sref_pkg::func_t'(in_func);
      req_code_r  <= in_error_code;
      req_first_r <= in_first_sequence;
      req_seq_r   <= in_sequence_req;
      idx_r       <= '0;
    end else if (cmd.scan_en && !sts.done) begin
      idx_r       <= idx_r + sref_pkg::IDX_W'(1);
    end
    if (cmd.scan_en && sts.done) begin
      res_ignored_r <= ignored_nxt;
      res_status_r  <= status_nxt;
    end
    if (cmd.load_out) begin
      out_ignored_r <= res_ignored_r;
      out_status_r  <= res_status_r;
    end
  end

  assign out_ignored = out_ignored_r;
  assign out_status  = out_status_r;

endmodule

FILE: src/sref_ctrl.sv
// ----------------------------------------------------------------------------
// Sequence range error filter controller
// Sequences capture, table scan and result hand-off, and owns the output
// valid flag.
// ----------------------------------------------------------------------------
module sref_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output sref_pkg::cmd_t  cmd,
  input  sref_pkg::sts_t  sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free    = !out_valid_r || out_ready;
  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.load_in  = in_valid && in_ready;
  assign cmd.scan_en  = (state_r == S_SCAN);
  assign cmd.load_out = (state_r == S_HOLD) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.load_in) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.done) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SCAN))
    else $error("accepted transfer did not start a scan");

  a_done_leaves_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_en && sts.done) |=> (state_r == S_HOLD))
    else $error("finished scan did not move to hold");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result load did not raise output valid");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !cmd.scan_en && !cmd.load_in)
    else $error("result loaded while a request is in progress");

endmodule

FILE: src/sequence_range_error_filter.sv
// A result passes from the scan to the result registers and then, once the output
// slot is free, to the output registers; a scan ends at a hit or at entry ENTRIES-1.
// A new request waits for idle; the scan covers one table entry per cycle.
// Retire always scans the whole table; open, close and check stop at the first hit.
// Reset clears every range valid flag and the output valid; the table needs no sweep.
// ----------------------------------------------------------------------------
// Sequence range error filter
// Keeps a table of suppression ranges and serves open, close, retire and
// check requests, returning one result per request.
// ----------------------------------------------------------------------------
module sequence_range_error_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_error_code,
  input  logic [31:0] in_first_sequence,
  input  logic [31:0] in_sequence_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ignored,
  output logic [1:0]  out_status
);

  sref_pkg::cmd_t cmd;
  sref_pkg::sts_t sts;

  sref_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sref_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_error_code     (in_error_code),
    .in_first_sequence (in_first_sequence),
    .in_sequence_req   (in_sequence_req),
    .out_ignored       (out_ignored),
    .out_status        (out_status)
  );

endmodule

FILE: tb/tb_sequence_range_error_filter.sv
// ----------------------------------------------------------------------------
// Sequence range error filter testbench
// Drives open, close, retire and check requests through the request channel
// and compares every result against a scoreboard that tracks its own copy of
// the range table. A directed opening is followed by random phases of
// mostly well-formed traffic, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sequence_range_error_filter;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 275;
  localparam int HOLD_AFTER    = 500;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = 24;

  typedef struct packed {
    logic       ignored;
    logic [1:0] status;
  } filter_result_t;

  class range_filter_scoreboard;
    bit          slot_used [sref_pkg::ENTRIES];
    logic [7:0]  slot_code [sref_pkg::ENTRIES];
    logic [31:0] slot_first[sref_pkg::ENTRIES];
    logic [31:0] slot_last [sref_pkg::ENTRIES];
    filter_result_t expected_q[$];
    int failures;

    function new();
      for (int i = 0; i < sref_pkg::ENTRIES; i++) begin
        slot_used[i] = 1'b0;
      end
      failures = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [1:0] func_bits, logic [7:0] code,
                             logic [31:0] first_seq, logic [31:0] seq);
      filter_result_t res;
      bit hit;
      res = '0;
      hit = 1'b0;
      case (sref_pkg::func_t'(func_bits))
        sref_pkg::FUNC_OPEN: begin
          res.status = sref_pkg::ST_FULL;
          for (int i = 0; i < sref_pkg::ENTRIES && !hit; i++) begin
            if (!slot_used[i]) begin
              slot_used[i]  = 1'b1;
              slot_code[i]  = code;
              slot_first[i] = seq;
              slot_last[i]  = '0;
              res.status    = sref_pkg::ST_OK;
              hit           = 1'b1;
            end
          end
        end
        sref_pkg::FUNC_CLOSE: begin
          res.status = sref_pkg::ST_NO_OPEN;
          for (int i = 0; i < sref_pkg::ENTRIES && !hit; i++) begin
            if (slot_used[i] && slot_code[i] == code && slot_first[i] == first_seq &&
                slot_last[i] == 32'd0) begin
              slot_last[i] = seq;
              res.status   = sref_pkg::ST_OK;
              hit          = 1'b1;
            end
          end
        end
        sref_pkg::FUNC_RETIRE: begin
          for (int i = 0; i < sref_pkg::ENTRIES; i++) begin
            if (slot_used[i] && slot_last[i] != 32'd0 && seq >= slot_last[i]) begin
              slot_used[i] = 1'b0;
            end
          end
        end
        default: begin
          for (int i = 0; i < sref_pkg::ENTRIES; i++) begin
            if (slot_used[i] && slot_code[i] == code && seq > slot_first[i] &&
                (slot_last[i] == 32'd0 || seq < slot_last[i])) begin
              res.ignored = 1'b1;
            end
          end
        end
      endcase
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void check_result(logic ignored, logic [1:0] status);
      filter_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: ignored %0d, status %0d", ignored, status);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (ignored !== want.ignored) begin
        $error("ignored: expected %0d, actual %0d", want.ignored, ignored);
        failures++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = '0;
  logic [7:0]  in_error_code = '0;
  logic [31:0] in_first_sequence = '0;
  logic [31:0] in_sequence_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_ignored;
  logic [1:0]  out_status;

  range_filter_scoreboard sb;
  int          items_sent = 0;
  int          burst_left = 1;
  logic [7:0]  code_pool[4];
  logic [31:0] seq_base;

  always #5 clk = ~clk;

  sequence_range_error_filter u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_error_code     (in_error_code),
    .in_first_sequence (in_first_sequence),
    .in_sequence_req   (in_sequence_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ignored       (out_ignored),
    .out_status        (out_status)
  );

  task automatic send_item(input logic [1:0] f, input logic [7:0] code,
                           input logic [31:0] first_seq, input logic [31:0] seq);
    int gap;
    in_valid          <= 1'b1;
    in_func           <= f;
    in_error_code     <= code;
    in_first_sequence <= first_seq;
    in_sequence_req   <= seq;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, code, first_seq, seq);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic make_item(input int phase, output logic [1:0] f, output logic [7:0] code,
                           output logic [31:0] first_seq, output logic [31:0] seq);
    int roll, slot, w_open, w_close, w_retire;
    bit found;
    code      = code_pool[$urandom_range(3)];
    first_seq = $urandom;
    seq       = $urandom;
    if ($urandom_range(99) < 12) begin
      f    = 2'($urandom_range(3));
      code = 8'($urandom);
      return;
    end
    case (phase % 3)
      0: begin
        w_open = 50; w_close = 20; w_retire = 5;
      end
      1: begin
        w_open = 30; w_close = 25; w_retire = 15;
      end
      default: begin
        w_open = 15; w_close = 35; w_retire = 25;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < w_open) f = sref_pkg::FUNC_OPEN;
    else if (roll < w_open + w_close) f = sref_pkg::FUNC_CLOSE;
    else if (roll < w_open + w_close + w_retire) f = sref_pkg::FUNC_RETIRE;
    else f = sref_pkg::FUNC_CHECK;
    found = 1'b0;
    slot = 0;
    for (int tries = 0; tries < 8 && !found; tries++) begin
      slot  = $urandom_range(sref_pkg::ENTRIES - 1);
      found = sb.slot_used[slot] &&
              (f != sref_pkg::FUNC_CLOSE || sb.slot_last[slot] == 32'd0) &&
              (f != sref_pkg::FUNC_RETIRE || sb.slot_last[slot] != 32'd0);
    end
    case (sref_pkg::func_t'(f))
      sref_pkg::FUNC_OPEN: begin
        case ($urandom_range(9))
          0: seq = 32'd0;
          1: seq = 32'hFFFF_FFFF;
          2, 3: seq = $urandom;
          default: seq = seq_base + $urandom_range(1000);
        endcase
      end
      sref_pkg::FUNC_CLOSE: begin
        if (found) begin
          code      = sb.slot_code[slot];
          first_seq = sb.slot_first[slot];
        end else begin
          first_seq = seq_base + $urandom_range(1000);
        end
        case ($urandom_range(9))
          0: seq = 32'd0;
          1: seq = first_seq;
          2: seq = first_seq + 32'd1;
          3: seq = first_seq - 32'd1;
          4: seq = $urandom;
          default: seq = first_seq + $urandom_range(2, 500);
        endcase
      end
      sref_pkg::FUNC_RETIRE: begin
        if (found && $urandom_range(3) != 0) begin
          seq = sb.slot_last[slot] + $urandom_range(2) - 32'd1;
        end else if ($urandom_range(3) == 0) begin
          seq = 32'hFFFF_FFFF;
        end else begin
          seq = seq_base + $urandom_range(1500);
        end
      end
      default: begin
        if (found) begin
          if ($urandom_range(9) != 0) code = sb.slot_code[slot];
          case ($urandom_range(8))
            0: seq = sb.slot_first[slot];
            1: seq = sb.slot_first[slot] + 32'd1;
            2: seq = sb.slot_first[slot] - 32'd1;
            3: seq = sb.slot_last[slot] - 32'd1;
            4: seq = sb.slot_last[slot];
            5: seq = sb.slot_last[slot] + 32'd1;
            6: seq = $urandom;
            default: seq = sb.slot_first[slot] + $urandom_range(1000);
          endcase
        end else begin
          seq = seq_base + $urandom_range(1500);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_ignored, out_status);
    end
  end

  initial begin
    int mode, mode_left, tick;
    bit held;
    mode = 0;
    mode_left = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(3);
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      tick++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(1));
        2: out_ready <= ($urandom_range(4) == 0);
        default: out_ready <= (tick % 4 == 0);
      endcase
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("sequence_range_error_filter: mismatch");
    $finish;
  end

  initial begin
    logic [1:0]  f;
    logic [7:0]  code;
    logic [31:0] first_seq, seq;
    sb = new();
    burst_left = $urandom_range(1, 24);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(sref_pkg::FUNC_CHECK,  8'h00, 32'h0000_0000, 32'd5);
    send_item(sref_pkg::FUNC_CLOSE,  8'h00, 32'h0000_0000, 32'd10);
    send_item(sref_pkg::FUNC_RETIRE, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(sref_pkg::FUNC_OPEN,   8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(sref_pkg::FUNC_OPEN,   8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(sref_pkg::FUNC_OPEN,   8'h5A, 32'h0000_0000, 32'd100);
    send_item(sref_pkg::FUNC_CHECK,  8'h00, 32'h0000_0000, 32'd0);
    send_item(sref_pkg::FUNC_CHECK,  8'h00, 32'hFFFF_FFFF, 32'd1);
    send_item(sref_pkg::FUNC_CHECK,  8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(sref_pkg::FUNC_CHECK,  8'hFF, 32'h0000_0000, 32'h0000_0000);
    send_item(sref_pkg::FUNC_CLOSE,  8'h5A, 32'd100,       32'd0);
    send_item(sref_pkg::FUNC_CHECK,  8'h5A, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(sref_pkg::FUNC_CLOSE,  8'h5A, 32'd100,       32'd101);
    send_item(sref_pkg::FUNC_CHECK,  8'h5A, 32'h0000_0000, 32'd101);
    send_item(sref_pkg::FUNC_OPEN,   8'h5A, 32'h0000_0000, 32'd100);
    send_item(sref_pkg::FUNC_OPEN,   8'h5A, 32'h0000_0000, 32'd100);
    send_item(sref_pkg::FUNC_CLOSE,  8'h5A, 32'd100,       32'd200);
    send_item(sref_pkg::FUNC_CHECK,  8'h5A, 32'h0000_0000, 32'd150);
    send_item(sref_pkg::FUNC_RETIRE, 8'h5A, 32'h0000_0000, 32'd101);
    send_item(sref_pkg::FUNC_CLOSE,  8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(sref_pkg::FUNC_CHECK,  8'h00, 32'h0000_0000, 32'hFFFF_FFFE);
    send_item(sref_pkg::FUNC_RETIRE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(sref_pkg::FUNC_CLOSE,  8'hA5, 32'hFFFF_FFFF, 32'd7);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES / 2) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      for (int i = 0; i < 4; i++) begin
        code_pool[i] = 8'($urandom);
      end
      seq_base = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        make_item(phase, f, code, first_seq, seq);
        send_item(f, code, first_seq, seq);
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("sequence_range_error_filter: match");
    end else begin
      $display("sequence_range_error_filter: mismatch");
    end
    $finish;
  end

endmodule
